FILE: design/aabb_pair_contact_tracker_macros.svh
// Assertion helpers shared by the contact tracker RTL.
// Both sample on clk and are disabled while rst_n is low.
`ifndef AABB_PAIR_CONTACT_TRACKER_MACROS_SVH
`define AABB_PAIR_CONTACT_TRACKER_MACROS_SVH

// General property check.
`define APCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication check.
`define APCT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: design/apct_pkg.sv
`default_nettype none

package apct_pkg;

    localparam int COORD_W = 16;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_ENTER = 2'd1,
        EV_STAY  = 2'd2,
        EV_EXIT  = 2'd3
    } contact_ev_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;   // write one zero entry of the table at the sweep pointer
        logic load;    // capture an accepted input transaction
        logic lookup;  // read the pair entry and evaluate the box test
        logic commit;  // update the entry and load the result register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;  // sweep pointer is at the last table entry
    } ctrl_sts_t;

endpackage

`default_nettype wire

FILE: design/aabb_pair_contact_tracker.sv
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+------------------------------------------
// input    | in        | in_valid / in_stall | left_id, right_cid, left/right x y w h
// result   | out       | out_valid/out_stall | contact_event, overlapping
//
// Each transaction is accepted, then reads the contact table, then updates the entry and
// loads the result, as set by the table memory's single write port and registered read.
// After reset a clearing pass zeroes all 2^(2*ID_BITS) table entries (4096 by default),
// with in_stall held high. A stalled result holds the item in its update step until
// the result register frees; the next transaction may be accepted while a result waits.
`default_nettype none

`include "aabb_pair_contact_tracker_macros.svh"

module aabb_pair_contact_tracker
    import apct_pkg::*;
#(
    parameter int ID_BITS = 6
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic        [ID_BITS-1:0] left_id,
    input  wire logic        [ID_BITS-1:0] right_cid,
    input  wire logic signed [COORD_W-1:0] left_x,
    input  wire logic signed [COORD_W-1:0] left_y,
    input  wire logic        [COORD_W-1:0] left_w,
    input  wire logic        [COORD_W-1:0] left_h,
    input  wire logic signed [COORD_W-1:0] right_x,
    input  wire logic signed [COORD_W-1:0] right_y,
    input  wire logic        [COORD_W-1:0] right_w,
    input  wire logic        [COORD_W-1:0] right_h,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic             [1:0]         contact_event,
    output logic                           overlapping
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    apct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    apct_datapath #(
        .ID_BITS (ID_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .left_id       (left_id),
        .right_cid     (right_cid),
        .left_x        (left_x),
        .left_y        (left_y),
        .left_w        (left_w),
        .left_h        (left_h),
        .right_x       (right_x),
        .right_y       (right_y),
        .right_w       (right_w),
        .right_h       (right_h),
        .contact_event (contact_event),
        .overlapping   (overlapping)
    );

    // One transaction in flight: the block is busy right after an accept.
    `APCT_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall,
                 "input accepted while previous transaction still in progress")

    `APCT_ASSERT_IMP(a_touch_overlaps,
                     out_valid && (contact_event == EV_ENTER || contact_event == EV_STAY),
                     overlapping, "enter or stay reported without overlap")

    `APCT_ASSERT_IMP(a_exit_separate, out_valid && (contact_event == EV_EXIT),
                     !overlapping, "exit reported while boxes still overlap")

    // A table update never coincides with the clearing pass.
    `APCT_ASSERT_IMP(a_no_commit_in_clear, cmd.clear, !cmd.commit && !cmd.lookup,
                     "table access during clearing pass")

endmodule

`default_nettype wire

FILE: design/apct_ram.sv
`default_nettype none

module apct_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/apct_ctrl.sv
`default_nettype none

module apct_ctrl
    import apct_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  wire logic      out_stall,
    output ctrl_cmd_t      cmd,
    input  wire ctrl_sts_t sts
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // The table entry is written only once the result has a slot.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: design/apct_datapath.sv
`default_nettype none

module apct_datapath
    import apct_pkg::*;
#(
    parameter int ID_BITS = 6
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ctrl_cmd_t                   cmd,
    output ctrl_sts_t                        sts,
    input  wire logic        [ID_BITS-1:0]   left_id,
    input  wire logic        [ID_BITS-1:0]   right_cid,
    input  wire logic signed [COORD_W-1:0]   left_x,
    input  wire logic signed [COORD_W-1:0]   left_y,
    input  wire logic        [COORD_W-1:0]   left_w,
    input  wire logic        [COORD_W-1:0]   left_h,
    input  wire logic signed [COORD_W-1:0]   right_x,
    input  wire logic signed [COORD_W-1:0]   right_y,
    input  wire logic        [COORD_W-1:0]   right_w,
    input  wire logic        [COORD_W-1:0]   right_h,
    output logic             [1:0]           contact_event,
    output logic                             overlapping
);

    localparam int ADDR_BITS = 2 * ID_BITS;
    localparam int DEPTH     = 1 << ADDR_BITS;

    logic        [ID_BITS-1:0]   lid_reg, rid_reg;
    logic signed [COORD_W-1:0]   lx_reg, ly_reg, rx_reg, ry_reg;
    logic        [COORD_W-1:0]   lw_reg, lh_reg, rw_reg, rh_reg;
    logic                        hit_reg, hit_next;
    logic        [ADDR_BITS-1:0] clr_cnt_reg;
    logic        [1:0]           event_reg, event_next;
    logic                        ovl_reg;

    logic        [ADDR_BITS-1:0] pair_idx;
    logic        [ADDR_BITS-1:0] waddr;
    logic                        we;
    logic                        wdata;
    logic                        prev;
    logic                        pair_ne;
    logic                        x_hit, y_hit;

    // Strict 1-D overlap: 2*|b - a| < sa + sb, all in 17 bits so nothing wraps.
    function automatic logic axis_hit(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input logic        [COORD_W-1:0] sa,
        input logic        [COORD_W-1:0] sb
    );
        logic signed [COORD_W:0] d;
        logic        [COORD_W:0] mag;
        logic        [COORD_W:0] twice;
        logic        [COORD_W:0] sum;
        d     = {b[COORD_W-1], b} - {a[COORD_W-1], a};
        mag   = d[COORD_W] ? (~d + 1'b1) : d;
        twice = {mag[COORD_W-1:0], 1'b0};
        sum   = {1'b0, sa} + {1'b0, sb};
        return twice < sum;
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lid_reg <= left_id;
            rid_reg <= right_cid;
            lx_reg  <= left_x;
            ly_reg  <= left_y;
            lw_reg  <= left_w;
            lh_reg  <= left_h;
            rx_reg  <= right_x;
            ry_reg  <= right_y;
            rw_reg  <= right_w;
            rh_reg  <= right_h;
        end
        if (cmd.lookup)
        begin
            hit_reg <= hit_next;
        end
        if (cmd.commit)
        begin
            event_reg <= event_next;
            ovl_reg   <= hit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign x_hit    = axis_hit(lx_reg, rx_reg, lw_reg, rw_reg);
    assign y_hit    = axis_hit(ly_reg, ry_reg, lh_reg, rh_reg);
    assign hit_next = x_hit && y_hit;

    assign pair_idx = {lid_reg, rid_reg};
    assign pair_ne  = (lid_reg != rid_reg);

    // A pair of equal IDs never writes the table.
    assign we    = cmd.clear || (cmd.commit && pair_ne);
    assign waddr = cmd.clear ? clr_cnt_reg : pair_idx;
    assign wdata = cmd.clear ? 1'b0 : hit_reg;

    apct_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_contact_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.lookup),
        .raddr (pair_idx),
        .rdata (prev)
    );

    always_comb
    begin
        event_next = EV_NONE;
        if (pair_ne)
        begin
            if (hit_reg)
            begin
                event_next = prev ? EV_STAY : EV_ENTER;
            end
            else if (prev)
            begin
                event_next = EV_EXIT;
            end
        end
    end

    assign sts.clear_last = (clr_cnt_reg == {ADDR_BITS{1'b1}});
    assign contact_event  = event_reg;
    assign overlapping    = ovl_reg;

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import apct_pkg::*;

    localparam int ID_W = 6;
    localparam int TABLE_SIZE = 1 << (2 * ID_W);
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic        [ID_W-1:0] lid;
        logic        [ID_W-1:0] rid;
        logic signed [15:0]     lx;
        logic signed [15:0]     ly;
        logic        [15:0]     lw;
        logic        [15:0]     lh;
        logic signed [15:0]     rx;
        logic signed [15:0]     ry;
        logic        [15:0]     rw;
        logic        [15:0]     rh;
    } box_pair_t;

    typedef struct {
        contact_ev_t ev;
        logic        touching;
    } contact_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic        [ID_W-1:0] left_id = '0;
    logic        [ID_W-1:0] right_cid = '0;
    logic signed [15:0]     left_x = '0;
    logic signed [15:0]     left_y = '0;
    logic        [15:0]     left_w = '0;
    logic        [15:0]     left_h = '0;
    logic signed [15:0]     right_x = '0;
    logic signed [15:0]     right_y = '0;
    logic        [15:0]     right_w = '0;
    logic        [15:0]     right_h = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] contact_event;
    logic overlapping;

    bit contact_seen [TABLE_SIZE];
    contact_result_t expected_contacts [$];
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    aabb_pair_contact_tracker #(
        .ID_BITS(ID_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .left_id(left_id),
        .right_cid(right_cid),
        .left_x(left_x),
        .left_y(left_y),
        .left_w(left_w),
        .left_h(left_h),
        .right_x(right_x),
        .right_y(right_y),
        .right_w(right_w),
        .right_h(right_h),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .contact_event(contact_event),
        .overlapping(overlapping)
    );

    always #10 clk = ~clk;

    // Strict overlap on one axis; 32-bit math keeps the doubled distance exact.
    function automatic logic axis_overlaps(logic signed [15:0] a, logic signed [15:0] b,
                                           logic [15:0] sa, logic [15:0] sb);
        int d;
        int mag;
        int span;
        d = int'(b) - int'(a);
        mag = (d < 0) ? -d : d;
        span = int'({16'd0, sa}) + int'({16'd0, sb});
        return (2 * mag < span);
    endfunction

    function automatic contact_result_t predict_contact(box_pair_t p);
        contact_result_t r;
        int idx;
        logic prev;
        r.touching = axis_overlaps(p.lx, p.rx, p.lw, p.rw) &&
                     axis_overlaps(p.ly, p.ry, p.lh, p.rh);
        r.ev = EV_NONE;
        if (p.lid != p.rid)
        begin
            idx = int'({p.lid, p.rid});
            prev = contact_seen[idx];
            if (r.touching)
                r.ev = prev ? EV_STAY : EV_ENTER;
            else if (prev)
                r.ev = EV_EXIT;
            contact_seen[idx] = r.touching;
        end
        return r;
    endfunction

    function automatic box_pair_t build_pair(int lid, int rid, int lx, int ly,
                                             int lw, int lh, int rx, int ry,
                                             int rw, int rh);
        box_pair_t p;
        p.lid = lid[ID_W-1:0];
        p.rid = rid[ID_W-1:0];
        p.lx = lx[15:0];
        p.ly = ly[15:0];
        p.lw = lw[15:0];
        p.lh = lh[15:0];
        p.rx = rx[15:0];
        p.ry = ry[15:0];
        p.rw = rw[15:0];
        p.rh = rh[15:0];
        return p;
    endfunction

    task automatic note_failure(string what);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("[%0t] ERROR: %s", $time, what);
    endtask

    // Drives one transaction and records its expected result once it is accepted.
    task automatic send_pair(box_pair_t p);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        left_id <= p.lid;
        right_cid <= p.rid;
        left_x <= p.lx;
        left_y <= p.ly;
        left_w <= p.lw;
        left_h <= p.lh;
        right_x <= p.rx;
        right_y <= p.ry;
        right_w <= p.rw;
        right_h <= p.rh;
        do
            @(posedge clk);
        while (in_stall);
        expected_contacts.push_back(predict_contact(p));
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_contacts.size() != 0)
            @(posedge clk);
    endtask

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        contact_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_contacts.size() == 0)
            begin
                note_failure($sformatf(
                    "result with nothing expected: event=%0d overlapping=%0b",
                    contact_event, overlapping));
            end
            else
            begin
                want = expected_contacts.pop_front();
                if (contact_event !== want.ev || overlapping !== want.touching)
                    note_failure($sformatf(
                        "expected event=%s overlapping=%0b, got event=%0d overlapping=%0b",
                        want.ev.name(), want.touching, contact_event, overlapping));
            end
        end
    end

    // Walks one pair through its contact states, then checks that the reversed
    // pair has an entry of its own and that equal IDs leave the table alone.
    task automatic test_event_sequence();
        send_pair(build_pair(3, 5, 0, 0, 16, 16, 1000, 0, 16, 16));
        send_pair(build_pair(3, 5, 0, 0, 16, 16, 8, 4, 16, 16));
        send_pair(build_pair(3, 5, 0, 0, 16, 16, -8, -4, 16, 16));
        send_pair(build_pair(3, 5, 0, 0, 16, 16, 0, 200, 16, 16));
        send_pair(build_pair(3, 5, 0, 0, 16, 16, 0, 200, 16, 16));
        send_pair(build_pair(5, 3, 50, 50, 20, 20, 55, 45, 20, 20));
        send_pair(build_pair(3, 5, 50, 50, 20, 20, 55, 45, 20, 20));
        send_pair(build_pair(9, 9, 0, 0, 100, 100, 10, 10, 100, 100));
        send_pair(build_pair(9, 9, 0, 0, 1, 1, 500, 500, 1, 1));
        send_pair(build_pair(5, 3, 0, 0, 10, 10, 300, 0, 10, 10));
    endtask

    // Zero sizes, exact touching on each axis, and the extremes of the coordinates.
    task automatic test_box_geometry();
        send_pair(build_pair(1, 2, 0, 0, 0, 50, 0, 0, 0, 50));
        send_pair(build_pair(1, 2, 0, 0, 65535, 0, 0, 0, 65535, 0));
        send_pair(build_pair(4, 6, 0, 0, 10, 2, 10, 0, 10, 2));
        send_pair(build_pair(4, 6, 0, 0, 10, 2, 10, 0, 11, 2));
        send_pair(build_pair(0, 63, -32768, 0, 65535, 65535, 32767, 0, 65535, 65535));
        send_pair(build_pair(0, 63, -32768, 0, 65535, 65535, 32766, 0, 65535, 65535));
        send_pair(build_pair(63, 0, 32767, 32767, 65535, 65535,
                             -32768, -32768, 65535, 65535));
        send_pair(build_pair(7, 8, 100, 0, 401, 1, -100, 0, 0, 1));
        send_pair(build_pair(7, 8, 0, -5, 100, 10, 0, 5, 100, 10));
        send_pair(build_pair(63, 63, -32768, -32768, 65535, 65535,
                             -32768, -32768, 65535, 65535));
    endtask

    // Mostly pairs from a small ID pool so contacts build up and break; boxes are
    // placed near each other so the outcome is close to even. The rest is equal
    // IDs and fully random transactions.
    task automatic test_random_tracks(int count);
        box_pair_t p;
        int kind;
        int span_x;
        int span_y;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(99);
            p.lid = ID_W'($urandom);
            p.rid = ID_W'($urandom);
            p.lx = 16'($urandom);
            p.ly = 16'($urandom);
            p.lw = 16'($urandom);
            p.lh = 16'($urandom);
            p.rx = 16'($urandom);
            p.ry = 16'($urandom);
            p.rw = 16'($urandom);
            p.rh = 16'($urandom);
            if (kind < 85)
            begin
                p.lid = ID_W'($urandom_range(10, 15));
                p.rid = ID_W'($urandom_range(10, 15));
                if (kind >= 75)
                    p.rid = p.lid;
                if ($urandom_range(3) != 0)
                begin
                    p.lw = 16'($urandom_range(0, 2047));
                    p.lh = 16'($urandom_range(0, 2047));
                    p.rw = 16'($urandom_range(0, 2047));
                    p.rh = 16'($urandom_range(0, 2047));
                end
                span_x = int'({16'd0, p.lw}) + int'({16'd0, p.rw});
                span_y = int'({16'd0, p.lh}) + int'({16'd0, p.rh});
                if ($urandom_range(1) == 0)
                begin
                    p.rx = 16'(int'(p.lx) + int'($urandom_range(0, span_x)) - span_x / 2);
                    p.ry = 16'(int'(p.ly) + int'($urandom_range(0, span_y)) - span_y / 2);
                end
                else
                begin
                    p.rx = 16'(int'(p.lx) + int'($urandom_range(0, 2 * span_x)) - span_x);
                    p.ry = 16'(int'(p.ly) + int'($urandom_range(0, 2 * span_y)) - span_y);
                end
            end
            send_pair(p);
            if (i == count / 2)
                wait_for_results();
        end
    endtask

    initial
    begin
        for (int i = 0; i < TABLE_SIZE; i++)
            contact_seen[i] = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 25;
        recv_idle_pct = 63;
        test_event_sequence();
        test_box_geometry();
        test_random_tracks(170);
        wait_for_results();

        send_idle_pct = 63;
        recv_idle_pct = 25;
        test_random_tracks(170);
        wait_for_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_tracks(170);
        wait_for_results();

        repeat (10) @(posedge clk);
        if (expected_contacts.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_contacts.size()));
        if (error_count == 0)
            $display("aabb_pair_contact_tracker verification clean");
        else
            $display("aabb_pair_contact_tracker verification failed");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("[%0t] timeout", $time);
        $display("aabb_pair_contact_tracker verification failed");
        $finish;
    end

endmodule
